/* sv/ptb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int TIME_BITS = 48;
  localparam int PERIOD_W  = 32;
  localparam int FUNC_W    = 2;
  localparam int DIVCNT_W  = $clog2(TIME_BITS + 1);

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic snap;
    logic scan_clear;
    logic scan_step;
    logic kill;
    logic div_start;
    logic div_step;
    logic rearm;
    logic set_pend;
    logic push_pend;
    logic push_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic scan_done;
    logic found;
    logic found_cancelled;
    logic period_zero;
    logic div_done;
    logic out_free;
    logic pend_valid;
  } stat_t;

endpackage
`default_nettype wire

/* sv/ptb_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface ptb_in_if;
  logic                               valid;
  logic                               ready;
  logic [ptb_pkg::FUNC_W-1:0]         func;
  logic [3:0]                         slot;
  logic [47:0]                        now_ms;
  logic [31:0]                        timeout_ms;
  logic [31:0]                        repeat_ms;
  modport source (output valid, func, slot, now_ms, timeout_ms, repeat_ms, input ready);
  modport sink (input valid, func, slot, now_ms, timeout_ms, repeat_ms, output ready);
endinterface

interface ptb_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] fired_slot;
  logic       last;
  modport source (output valid, fired_slot, last, input ready);
  modport sink (input valid, fired_slot, last, output ready);
endinterface
`default_nettype wire

/* sv/ptb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module ptb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ptb_pkg::stat_t stat,
  output ptb_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SCAN, S_EVAL, S_DIV, S_UPDATE, S_RECORD, S_FLUSH
  } state_t;

  state_t state, state_next;

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid && stat.in_tick) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.snap       = 1'b1;
        cmd.scan_clear = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = S_EVAL;
      end
      S_EVAL: begin
        priority if (!stat.found) begin
          state_next = S_FLUSH;
        end else if (stat.found_cancelled) begin
          cmd.kill       = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end else if (stat.period_zero) begin
          cmd.kill   = 1'b1;
          state_next = S_RECORD;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_UPDATE;
        else cmd.div_step = 1'b1;
      end
      S_UPDATE: begin
        cmd.rearm  = 1'b1;
        state_next = S_RECORD;
      end
      S_RECORD: begin
        if (!stat.pend_valid || stat.out_free) begin
          cmd.push_pend  = stat.pend_valid;
          cmd.set_pend   = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.push_pend = 1'b1;
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.in_ready |-> (state == S_IDLE)) else $error("ready outside idle");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push_pend |-> stat.out_free) else $error("push into busy output");
  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && $past(state) == S_EVAL) |-> !stat.div_done)
    else $error("divider finished at once");

endmodule
`default_nettype wire

/* sv/ptb_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module ptb_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ptb_pkg::cmd_t cmd,
  output ptb_pkg::stat_t     stat,
  ptb_in_if.sink             inp,
  ptb_out_if.source          outp
);

  localparam int TB = ptb_pkg::TIME_BITS;
  localparam int PW = ptb_pkg::PERIOD_W;
  localparam int SW = ptb_pkg::SLOT_W;
  localparam int NS = ptb_pkg::SLOTS;

  logic [TB-1:0] dl [NS];
  logic [PW-1:0] per [NS];
  logic [NS-1:0] armed, canc, due;
  logic [TB-1:0] now_q;

  logic [SW-1:0] idx, best_idx;
  logic          best_valid;
  logic [TB-1:0] best_dl;

  logic [TB-1:0]       dq;
  logic [PW-1:0]       rem;
  logic [ptb_pkg::DIVCNT_W-1:0] dcnt;

  logic          pend_valid;
  logic [SW-1:0] pend_slot;
  logic          out_valid;

  logic          accept;
  logic [TB:0]   start_sum, rearm_sum;
  logic [TB-1:0] start_dl, rearm_dl, now_in;
  logic [PW:0]   div_sh;
  logic          take;

  assign accept = inp.valid && cmd.in_ready;
  assign now_in = inp.now_ms[TB-1:0];

  // Saturating deadline for a start, and for a periodic re-arm.
  assign start_sum = {1'b0, now_in} + (TB + 1)'(inp.timeout_ms);
  assign start_dl  = start_sum[TB] ? '1 : start_sum[TB-1:0];
  assign rearm_sum = {1'b0, now_q} + (TB + 1)'(per[best_idx] - rem);
  assign rearm_dl  = rearm_sum[TB] ? '1 : rearm_sum[TB-1:0];

  // One step of the restoring remainder.
  assign div_sh = {rem, dq[TB-1]};

  // A scanned slot replaces the best if due and strictly earlier.
  assign take = due[idx] && (!best_valid || dl[idx] < best_dl);

  // Slot table: start and stop writes, tick snapshot, kill and re-arm.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
      canc  <= '0;
      due   <= '0;
      for (int i = 0; i < NS; i++) begin
        dl[i]  <= '0;
        per[i] <= '0;
      end
    end else begin
      if (accept && inp.func == ptb_pkg::FUNC_START) begin
        per[inp.slot[SW-1:0]]  <= inp.repeat_ms;
        canc[inp.slot[SW-1:0]] <= 1'b0;
        if (!armed[inp.slot[SW-1:0]]) begin
          dl[inp.slot[SW-1:0]]    <= start_dl;
          armed[inp.slot[SW-1:0]] <= 1'b1;
        end
      end
      if (accept && inp.func == ptb_pkg::FUNC_STOP) begin
        canc[inp.slot[SW-1:0]] <= 1'b1;
        per[inp.slot[SW-1:0]]  <= '0;
      end
      if (cmd.snap) begin
        for (int i = 0; i < NS; i++) due[i] <= armed[i] && (dl[i] <= now_q);
      end
      if (cmd.kill) begin
        armed[best_idx] <= 1'b0;
        dl[best_idx]    <= '0;
        due[best_idx]   <= 1'b0;
      end
      if (cmd.rearm) begin
        dl[best_idx]  <= rearm_dl;
        due[best_idx] <= 1'b0;
      end
    end
  end

  // Time of the current item.
  always_ff @(posedge clk) begin
    if (accept) now_q <= now_in;
  end

  // Scan for the earliest due slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      best_valid <= 1'b0;
    end else if (cmd.scan_clear) begin
      idx        <= '0;
      best_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      if (idx != SW'(NS - 1)) idx <= idx + 1'b1;
      if (take) begin
        best_valid <= 1'b1;
        best_idx   <= idx;
        best_dl    <= dl[idx];
      end
    end
  end

  // Remainder of (now - deadline) by the period, one bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dq   <= now_q - best_dl;
      rem  <= '0;
      dcnt <= ptb_pkg::DIVCNT_W'(TB);
    end else if (cmd.div_step) begin
      dq   <= dq << 1;
      dcnt <= dcnt - 1'b1;
      if (div_sh >= {1'b0, per[best_idx]}) rem <= PW'(div_sh - {1'b0, per[best_idx]});
      else rem <= div_sh[PW-1:0];
    end
  end

  // Held result and output register: a result leaves once the next is known.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.push_pend) begin
        out_valid       <= 1'b1;
        outp.fired_slot <= 4'(pend_slot);
        outp.last       <= cmd.push_last;
      end else if (outp.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.set_pend) begin
        pend_valid <= 1'b1;
        pend_slot  <= best_idx;
      end else if (cmd.push_pend) begin
        pend_valid <= 1'b0;
      end
    end
  end

  assign outp.valid = out_valid;
  assign inp.ready  = cmd.in_ready;

  always_comb begin
    stat.in_valid        = inp.valid;
    stat.in_tick         = (inp.func == ptb_pkg::FUNC_TICK);
    stat.scan_done       = (idx == SW'(NS - 1));
    stat.found           = best_valid;
    stat.found_cancelled = canc[best_idx];
    stat.period_zero     = (per[best_idx] == '0);
    stat.div_done        = (dcnt == '0);
    stat.out_free        = !out_valid || outp.ready;
    stat.pend_valid      = pend_valid;
  end

  a_pick_due: assert property (@(posedge clk) disable iff (rst)
    (cmd.kill || cmd.rearm) |-> (best_valid && due[best_idx]))
    else $error("serviced slot not due");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    cmd.rearm |-> (rem < per[best_idx])) else $error("remainder not below period");
  a_rearm_future: assert property (@(posedge clk) disable iff (rst)
    cmd.rearm |-> (rearm_dl > now_q || rearm_dl == '1)) else $error("re-arm not past now");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_pend && cmd.push_last) |=> !pend_valid) else $error("held result after last");

endmodule
`default_nettype wire

/* sv/periodic_timer_bank_scheduler_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bank of 16 millisecond timer slots. Start and stop transactions are taken
// straight from idle, and the input stays ready for the next transaction. A
// tick transaction holds the input off while it works. After acceptance it
// takes a snapshot, then scans the slots through one comparator and evaluates
// the earliest due slot, once for each due slot. Each fired slot is recorded,
// and each periodic re-arm first runs the bit-serial remainder unit, which
// runs 48 steps. A final scan finds nothing due and ends in the flush; a full
// output register stalls the record and the flush. Fired slots come out in
// deadline order, the final one of a tick marked by last.
module periodic_timer_bank_scheduler_unit (
  input wire logic  clk,
  input wire logic  rst,
  ptb_in_if.sink    in_ch,
  ptb_out_if.source out_ch
);

  ptb_pkg::cmd_t  cmd;
  ptb_pkg::stat_t stat;

  ptb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  ptb_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .inp  (in_ch),
    .outp (out_ch)
  );

endmodule
`default_nettype wire

/* tb/ptb_tb_if.sv */
`timescale 1ns / 1ps
// The block's own interfaces are used directly; this file holds the
// transaction types that the driver queue and the expectation store share.
package ptb_tb_types;
  import ptb_pkg::*;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [3:0]        slot;
    logic [47:0]       now_ms;
    logic [31:0]       timeout_ms;
    logic [31:0]       repeat_ms;
  } timer_cmd_t;

  typedef struct packed {
    logic [3:0] fired_slot;
    logic       last;
  } fire_t;
endpackage

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import ptb_pkg::*;
  import ptb_tb_types::*;

  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptb_in_if  in_ch ();
  ptb_out_if out_ch ();

  periodic_timer_bank_scheduler_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Shadow copy of the timer bank.
  logic [47:0] sh_deadline [SLOTS];
  logic [31:0] sh_period   [SLOTS];
  logic        sh_armed    [SLOTS];
  logic        sh_cancel   [SLOTS];

  timer_cmd_t pending_cmds[$];
  fire_t      fires_expected[$];
  int         errors = 0;
  int         fire_count = 0;
  logic [47:0] clock_ms = 48'd1000;
  bit         quiet_mode = 1'b0;
  bit         hold_sender = 1'b0;
  int         long_stall = 0;
  bit         in_taken = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic logic [47:0] sat_sum(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? TMAX : s[47:0];
  endfunction

  // Apply one command to the shadow bank and queue the slots it fires.
  task automatic advance_bank(input timer_cmd_t c);
    bit due [SLOTS];
    int pick;
    int n;
    logic [47:0] rem;
    n = 0;
    if (c.func == FUNC_START) begin
      sh_period[c.slot] = c.repeat_ms;
      sh_cancel[c.slot] = 1'b0;
      if (!sh_armed[c.slot]) begin
        sh_deadline[c.slot] = sat_sum(c.now_ms, {16'd0, c.timeout_ms});
        sh_armed[c.slot] = 1'b1;
      end
    end else if (c.func == FUNC_STOP) begin
      sh_cancel[c.slot] = 1'b1;
      sh_period[c.slot] = '0;
    end else if (c.func == FUNC_TICK) begin
      for (int i = 0; i < SLOTS; i++)
        due[i] = sh_armed[i] && sh_deadline[i] <= c.now_ms;
      forever begin
        pick = -1;
        for (int i = 0; i < SLOTS; i++)
          if (due[i] && (pick < 0 || sh_deadline[i] < sh_deadline[pick])) pick = i;
        if (pick < 0) break;
        due[pick] = 1'b0;
        if (sh_cancel[pick]) begin
          sh_armed[pick] = 1'b0;
          sh_deadline[pick] = '0;
          continue;
        end
        if (sh_period[pick] == 0) begin
          sh_armed[pick] = 1'b0;
          sh_deadline[pick] = '0;
        end else begin
          rem = (c.now_ms - sh_deadline[pick]) % {16'd0, sh_period[pick]};
          sh_deadline[pick] = sat_sum(c.now_ms, {16'd0, sh_period[pick]} - rem);
        end
        fires_expected.push_back('{fired_slot: pick[3:0], last: 1'b0});
        n++;
      end
      if (n > 0) fires_expected[$].last = 1'b1;
    end
  endtask

  // Predict each command at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      advance_bank('{func: in_ch.func, slot: in_ch.slot, now_ms: in_ch.now_ms,
                     timeout_ms: in_ch.timeout_ms, repeat_ms: in_ch.repeat_ms});
      in_taken = 1'b1;
    end
  end

  // Driver: presents queued commands, moving on once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_taken = 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (pending_cmds.size() > 0 && !hold_sender &&
          (quiet_mode || $urandom_range(0, 5) != 0)) begin
        in_ch.valid      <= 1'b1;
        {in_ch.func, in_ch.slot, in_ch.now_ms, in_ch.timeout_ms, in_ch.repeat_ms}
          <= pending_cmds.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
        if (!quiet_mode && pending_cmds.size() > 0 && !hold_sender)
          hold_sender = ($urandom_range(0, 1) == 1);
      end
    end
  end

  // Sender gap bursts: the flag above is released again after a randomly drawn wait.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_sender) begin
        repeat ($urandom_range(1, 13)) @(negedge clk);
        hold_sender = 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down one cycle at a time.
  always @(posedge clk) begin
    if (long_stall > 0) long_stall--;
  end

  // Receiver readiness, with random stall bursts and one long hold-off.
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_stall > 0) begin
      out_ch.ready <= 1'b0;
    end else if (quiet_mode) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: compare each fired-slot transaction with the oldest expectation.
  always @(posedge clk) begin
    fire_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      fire_count++;
      if (fires_expected.size() == 0) begin
        report($sformatf("unexpected fire of slot %0d", out_ch.fired_slot));
      end else begin
        want = fires_expected.pop_front();
        if (out_ch.fired_slot !== want.fired_slot)
          report($sformatf("fired_slot %0d, expected %0d", out_ch.fired_slot,
                           want.fired_slot));
        if (out_ch.last !== want.last)
          report($sformatf("last %0b, expected %0b on slot %0d", out_ch.last,
                           want.last, want.fired_slot));
      end
    end
  end

  function automatic timer_cmd_t make_cmd(input logic [FUNC_W-1:0] f, input int s,
                                          input logic [47:0] t, input logic [31:0] tmo,
                                          input logic [31:0] rep);
    return '{func: f, slot: s[3:0], now_ms: t, timeout_ms: tmo, repeat_ms: rep};
  endfunction

  // Random command: mostly small timeouts and periods near the running clock.
  function automatic timer_cmd_t random_cmd();
    logic [31:0] tmo;
    logic [31:0] rep;
    int r;
    r = $urandom_range(0, 99);
    tmo = (r < 8) ? $urandom() : $urandom_range(0, 60);
    rep = (r % 5 == 0) ? 32'd0 : ((r > 95) ? $urandom() : $urandom_range(1, 40));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        clock_ms = clock_ms + $urandom_range(0, 30);
        return make_cmd(FUNC_TICK, 0, clock_ms, $urandom(), $urandom());
      end
      4, 5, 6, 7: return make_cmd(FUNC_START, $urandom_range(0, 15), clock_ms, tmo, rep);
      8: return make_cmd(FUNC_STOP, $urandom_range(0, 15), clock_ms, $urandom(), $urandom());
      default: return make_cmd(FUNC_NONE, $urandom_range(0, 15), $urandom(), $urandom(),
                               $urandom());
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_ch.valid || fires_expected.size() > 0)
      @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_TICK;
    in_ch.slot = '0;
    in_ch.now_ms = '0;
    in_ch.timeout_ms = '0;
    in_ch.repeat_ms = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_deadline[i] = '0;
      sh_period[i] = '0;
      sh_armed[i] = 1'b0;
      sh_cancel[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: immediate one-shot, tie order, periodic catch-up, cancel,
    // start on an armed slot, saturation, unused code, empty tick.
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 48'd0, '0, '0));
    pending_cmds.push_back(make_cmd(FUNC_START, 15, 48'd10, 32'd0, 32'd0));
    pending_cmds.push_back(make_cmd(FUNC_START, 3, 48'd10, 32'd5, 32'd0));
    pending_cmds.push_back(make_cmd(FUNC_START, 1, 48'd10, 32'd5, 32'd7));
    pending_cmds.push_back(make_cmd(FUNC_START, 0, 48'd10, 32'd2, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(FUNC_START, 1, 48'd11, 32'd900, 32'd3));
    pending_cmds.push_back(make_cmd(FUNC_START, 5, 48'd10, 32'd1, 32'd4));
    pending_cmds.push_back(make_cmd(FUNC_STOP, 5, 48'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(FUNC_NONE, 15, TMAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 48'd40, '0, '0));
    pending_cmds.push_back(make_cmd(FUNC_START, 7, 48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF, 32'd9));
    pending_cmds.push_back(make_cmd(FUNC_START, 8, 48'd50, 32'd0, 32'h8000_0000));
    pending_cmds.push_back(make_cmd(FUNC_STOP, 9, 48'd50, '0, '0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, TMAX, '0, '0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, TMAX, '0, '0));
    pending_cmds.push_back(make_cmd(FUNC_STOP, 0, TMAX, '0, '0));
    pending_cmds.push_back(make_cmd(FUNC_STOP, 7, TMAX, '0, '0));
    pending_cmds.push_back(make_cmd(FUNC_STOP, 8, TMAX, '0, '0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, TMAX, '0, '0));
    wait_drained();

    // Pressure: arm every slot due at once, then hold off the receiver.
    for (int i = 0; i < SLOTS; i++)
      pending_cmds.push_back(make_cmd(FUNC_START, i, clock_ms, 32'd0, (i % 2) ? 32'd5 : 32'd0));
    long_stall = 3000;
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, clock_ms + 3, '0, '0));
    for (int i = 0; i < 6; i++) pending_cmds.push_back(random_cmd());
    wait_drained();

    // Random body; then a final stretch without idling.
    for (int k = 0; k < 340; k++) begin
      if (k == 300) begin
        while (pending_cmds.size() > 0) @(posedge clk);
        quiet_mode = 1'b1;
      end
      pending_cmds.push_back(random_cmd());
      if (pending_cmds.size() > 8) @(posedge clk);
    end
    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end
endmodule

/* sim.f */
sv/ptb_pkg.sv
sv/ptb_if.sv
sv/ptb_ctrl.sv
sv/ptb_dp.sv
sv/periodic_timer_bank_scheduler_unit.sv
tb/ptb_tb_if.sv
tb/testbench.sv
